/* rtl/core/fanout_tree_span_top_defines.svh */
// Assertion macros shared by the fanout tree span RTL.
`ifndef FANOUT_TREE_SPAN_TOP_DEFINES_SVH
`define FANOUT_TREE_SPAN_TOP_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fanout tree span check failed");

// Consequence must hold in the cycle after the antecedent.
`define FTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fanout tree span check failed");

`endif

/* rtl/core/fts_pkg.sv */
// Package with widths, limits and shared types of the fanout tree span block.
`timescale 1ns / 1ps

package fts_pkg;

  localparam int NODE_W     = 20;
  localparam int WIDTH_W    = 7;
  localparam int BR_W       = 6;
  localparam int REM_W      = 6;
  localparam int SPAN_W     = NODE_W + WIDTH_W;
  localparam int LVL_W      = 5;
  localparam int DIV_CNT_W  = 5;

  localparam int MAX_WIDTH    = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int WIDTH_CAP    = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;

  localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH_RST = WIDTH_W'(16);

  typedef struct packed {
    logic               start;
    logic [NODE_W-1:0]  dividend;
    logic [WIDTH_W-1:0] divisor;
  } fts_div_req_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] quo;
    logic [REM_W-1:0]  rem;
  } fts_div_res_t;

endpackage

/* rtl/core/fts_div.sv */
// Radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module fts_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fts_pkg::fts_div_req_t req_i,
  output fts_pkg::fts_div_res_t res_o
);
  import fts_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NODE_W-1:0]    dvd_q;
  logic [REM_W-1:0]     r_q;
  logic [WIDTH_W-1:0]   dsr_q;

  logic [WIDTH_W-1:0]   shifted;
  logic                 qbit;
  logic [WIDTH_W-1:0]   diff;

  assign shifted = {r_q, dvd_q[NODE_W-1]};
  assign qbit    = (shifted >= dsr_q);
  assign diff    = shifted - dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      r_q    <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        r_q    <= '0;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        // The partial remainder stays below the divisor, so it fits REM_W bits.
        r_q   <= qbit ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        dvd_q <= {dvd_q[NODE_W-2:0], qbit};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(NODE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = dvd_q;
  assign res_o.rem  = r_q;

endmodule

/* rtl/core/fanout_tree_span_top.sv */
// Top level of the fanout tree span block: level sequencer, divider and result emitter.
`timescale 1ns / 1ps
`include "fanout_tree_span_top_defines.svh"

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    total_nodes_i, width_i
// out       output     out_valid_o / out_ready_i  branch_o, nodes_below_o, depth_o,
//                                                 direct_o, error_o, last_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_default_width_i
//
// A request with a zero node count, a direct reach or a fan-out of one yields one result.
// A tree request passes through ST_MUL and ST_CMP for each level opened (multiply, then
// compare and subtract), then waits in ST_DIV while the bit-serial divider splits the
// remainder of the last level (skipped when that remainder is zero), and then emits one
// result per branch from ST_EMIT.
// The block takes one request at a time; the last result of a request may still wait
// in the output register while the next request is taken.
// Reset clears the sequencer and the output valid and sets the default fan-out to 16.
// A low out_ready_i holds a pending result in the output register and stalls the emitter in place.
module fanout_tree_span_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [fts_pkg::NODE_W-1:0] total_nodes_i,
  input  logic [fts_pkg::WIDTH_W-1:0] width_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [fts_pkg::BR_W-1:0]   branch_o,
  output logic [fts_pkg::NODE_W-1:0] nodes_below_o,
  output logic [fts_pkg::NODE_W-1:0] depth_o,
  output logic                       direct_o,
  output logic                       error_o,
  output logic                       last_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fts_pkg::WIDTH_W-1:0] cfg_default_width_i
);
  import fts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Which single-result request is waiting in ST_ONE.
  typedef enum logic [1:0] {
    K_ERR,
    K_DIRECT,
    K_CHAIN
  } kind_e;

  state_e              state_q;
  kind_e               kind_q;
  logic [WIDTH_W-1:0]  dw_q;
  logic [WIDTH_W-1:0]  wid_q;
  logic [NODE_W-1:0]   rem_q;
  logic [NODE_W-1:0]   bcap_q;
  logic [SPAN_W-1:0]   lcap_q;
  logic [NODE_W-1:0]   base_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [NODE_W-1:0]   quo_q;
  logic [REM_W-1:0]    ext_q;
  logic [BR_W-1:0]     idx_q;

  logic                out_valid_q;
  logic [BR_W-1:0]     branch_q;
  logic [NODE_W-1:0]   nodes_q;
  logic [NODE_W-1:0]   depth_q;
  logic                direct_q;
  logic                error_q;
  logic                last_q;

  logic [WIDTH_W-1:0]  w_sel;
  logic [WIDTH_W-1:0]  w_eff;
  logic                in_acc;
  logic                out_free;
  logic [SPAN_W-1:0]   prod;
  logic                fits;
  logic [NODE_W-1:0]   rem_after;
  logic [NODE_W-1:0]   span_nodes;
  logic                is_last_br;

  fts_div_req_t        div_req;
  fts_div_res_t        div_res;

  // Effective fan-out: zero picks the default, a zero default counts as one,
  // and anything above the cap saturates.
  always_comb begin
    w_sel = (width_i != '0) ? width_i : dw_q;
    if (w_sel == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (w_sel > WIDTH_W'(WIDTH_CAP)) begin
      w_eff = WIDTH_W'(WIDTH_CAP);
    end else begin
      w_eff = w_sel;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // Capacity of the next level is the branch capacity times the fan-out;
  // after a full level the branch capacity becomes that product.
  assign prod      = bcap_q * wid_q;
  assign fits      = (lcap_q <= {{WIDTH_W{1'b0}}, rem_q});
  assign rem_after = rem_q - lcap_q[NODE_W-1:0];

  // Each branch gets the full-level share plus the even split of the remainder,
  // and the leading branches one node more.
  assign span_nodes = base_q + quo_q + NODE_W'(idx_q < ext_q);
  assign is_last_br = ({1'b0, idx_q} == (wid_q - WIDTH_W'(1)));

  assign div_req.start    = (state_q == ST_CMP) && !fits;
  assign div_req.dividend = rem_q;
  assign div_req.divisor  = wid_q;

  fts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q <= DEFAULT_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dw_q <= cfg_default_width_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= K_ERR;
      wid_q       <= '0;
      rem_q       <= '0;
      bcap_q      <= '0;
      lcap_q      <= '0;
      base_q      <= '0;
      lvl_q       <= '0;
      quo_q       <= '0;
      ext_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      branch_q    <= '0;
      nodes_q     <= '0;
      depth_q     <= '0;
      direct_q    <= 1'b0;
      error_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      // The emitting states load the next result whenever the output is taken, so the
      // valid is only dropped here while no result is being produced.
      if (out_ready_i && (state_q != ST_ONE) && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            wid_q  <= w_eff;
            rem_q  <= total_nodes_i;
            bcap_q <= NODE_W'(1);
            base_q <= '0;
            lvl_q  <= '0;
            idx_q  <= '0;
            if (total_nodes_i == '0) begin
              kind_q  <= K_ERR;
              state_q <= ST_ONE;
            end else if (total_nodes_i <= NODE_W'(w_eff)) begin
              kind_q  <= K_DIRECT;
              state_q <= ST_ONE;
            end else if (w_eff == WIDTH_W'(1)) begin
              kind_q  <= K_CHAIN;
              state_q <= ST_ONE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_ONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            branch_q    <= '0;
            last_q      <= 1'b1;
            unique case (kind_q)
              K_ERR: begin
                nodes_q  <= '0;
                depth_q  <= '0;
                direct_q <= 1'b0;
                error_q  <= 1'b1;
              end
              K_DIRECT: begin
                nodes_q  <= rem_q;
                depth_q  <= NODE_W'(1);
                direct_q <= 1'b1;
                error_q  <= 1'b0;
              end
              K_CHAIN: begin
                nodes_q  <= rem_q;
                depth_q  <= rem_q;
                direct_q <= 1'b0;
                error_q  <= 1'b0;
              end
              default: begin
                nodes_q  <= '0;
                depth_q  <= '0;
                direct_q <= 1'b0;
                error_q  <= 1'b1;
              end
            endcase
            state_q <= ST_IDLE;
          end
        end
        ST_MUL: begin
          lcap_q  <= prod;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          lvl_q <= lvl_q + 1'b1;
          if (fits) begin
            rem_q  <= rem_after;
            base_q <= base_q + bcap_q;
            bcap_q <= lcap_q[NODE_W-1:0];
            if (rem_after == '0) begin
              quo_q   <= '0;
              ext_q   <= '0;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_MUL;
            end
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            quo_q   <= div_res.quo;
            ext_q   <= div_res.rem;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            branch_q    <= idx_q;
            nodes_q     <= span_nodes;
            depth_q     <= NODE_W'(lvl_q);
            direct_q    <= 1'b0;
            error_q     <= 1'b0;
            last_q      <= is_last_br;
            idx_q       <= idx_q + 1'b1;
            if (is_last_br) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign branch_o      = branch_q;
  assign nodes_below_o = nodes_q;
  assign depth_o       = depth_q;
  assign direct_o      = direct_q;
  assign error_o       = error_q;
  assign last_o        = last_q;

  // An accepted request still occupies the sequencer in the cycle after it is taken.
  `FTS_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_o)
  // The divider only reports back while the sequencer is waiting for it.
  `FTS_ASSERT_NOW(a_div_done_in_div, div_res.done, state_q == ST_DIV)
  // An error result carries no span and closes its request.
  `FTS_ASSERT_NOW(a_error_result, out_valid_o && error_o, nodes_below_o == '0 && depth_o == '0 && last_o && !direct_o)
  // A direct result has depth one and closes its request.
  `FTS_ASSERT_NOW(a_direct_result, out_valid_o && direct_o, depth_o == NODE_W'(1) && last_o && !error_o && branch_o == '0)

endmodule
